FILE: src/lprt_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers for the longest prefix route table.
package lprt_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DELETE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam logic [5:0] MAX_LEN = 6'd32;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] address;
    logic [5:0]  prefix_length;
    logic [7:0]  interface_index;
    logic [31:0] next_hop;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_next_hop;
    logic [7:0]  out_interface;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] prefix;
    logic [5:0]  length;
    logic [7:0]  ifc;
    logic [31:0] nh;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic sample;
  } scan_ctrl_t;

  typedef struct packed {
    logic exact_hit;
    logic free_hit;
    logic best_hit;
  } scan_flags_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len == 6'd0) begin
      m = 32'h0;
    end else if (len >= MAX_LEN) begin
      m = 32'hffff_ffff;
    end else begin
      m = 32'hffff_ffff << (MAX_LEN - len);
    end
    return m;
  endfunction

endpackage

FILE: src/lprt_mem.sv
`timescale 1ns / 1ps
// Route entry store: one write port, one registered read port.
module lprt_mem import lprt_pkg::*; #(
  parameter  int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [IDX_W-1:0]           wr_addr,
  input  entry_t                     wr_data,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_addr,
  output entry_t                     rd_data
);

  entry_t mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: src/lprt_scan.sv
`timescale 1ns / 1ps
// Per-entry match logic and running exact, free and longest-match results.
module lprt_scan import lprt_pkg::*; #(
  parameter  int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  scan_ctrl_t        ctrl,
  input  logic [31:0]       key,
  input  logic [5:0]        len,
  input  entry_t            rd_data,
  input  logic [IDX_W-1:0]  rd_idx,
  output scan_flags_t       flags,
  output logic [IDX_W-1:0]  exact_slot,
  output logic [IDX_W-1:0]  free_slot,
  output logic [31:0]       best_nh,
  output logic [7:0]        best_ifc
);

  logic       is_exact;
  logic       is_free;
  logic       is_match;
  logic       is_better;
  logic [5:0] best_len;

  always_comb begin
    is_exact  = rd_data.valid && (rd_data.prefix == key) && (rd_data.length == len);
    is_free   = !rd_data.valid;
    is_match  = rd_data.valid && ((key & len_mask(rd_data.length)) == rd_data.prefix);
    is_better = is_match && (!flags.best_hit || (rd_data.length > best_len));
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      flags <= '0;
    end else if (ctrl.sample) begin
      if (is_exact) flags.exact_hit <= 1'b1;
      if (is_free)  flags.free_hit  <= 1'b1;
      if (is_better) flags.best_hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.sample) begin
      if (is_exact && !flags.exact_hit) exact_slot <= rd_idx;
      if (is_free && !flags.free_hit)   free_slot  <= rd_idx;
      if (is_better) begin
        best_len <= rd_data.length;
        best_nh  <= rd_data.nh;
        best_ifc <= rd_data.ifc;
      end
    end
  end

endmodule

FILE: src/longest_prefix_route_table_unit.sv
`timescale 1ns / 1ps
// Top level: command port, sequencer and result register of the route table.
//
// Each accepted command scans every table slot once, one slot per cycle through
// the entry memory's single read port; busy stays high through the scan, drain
// and finish states, and the result beat appears, with done high for one cycle,
// in the first cycle that busy is low again, when a new command may already be
// started. After reset busy is held high while every slot is written invalid.
// Results cannot be held off: sample rsp whenever done is high.
module longest_prefix_route_table_unit import lprt_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  state_t           state, state_next;
  logic [IDX_W-1:0] cnt, cnt_next;
  logic             rd_valid;
  logic [IDX_W-1:0] rd_idx;

  logic [1:0]       op_mode;
  logic [31:0]      op_key;
  logic [5:0]       op_len;
  logic [7:0]       op_ifc;
  logic [31:0]      op_nh;

  logic             accept;
  logic [5:0]       len_sat;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;
  logic             rd_en;
  entry_t           rd_data;

  scan_ctrl_t       sctrl;
  scan_flags_t      flags;
  logic [IDX_W-1:0] exact_slot;
  logic [IDX_W-1:0] free_slot;
  logic [31:0]      best_nh;
  logic [7:0]       best_ifc;

  logic             done_next;
  rsp_t             rsp_next;

  lprt_mem #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  lprt_scan #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (sctrl),
    .key        (op_key),
    .len        (op_len),
    .rd_data    (rd_data),
    .rd_idx     (rd_idx),
    .flags      (flags),
    .exact_slot (exact_slot),
    .free_slot  (free_slot),
    .best_nh    (best_nh),
    .best_ifc   (best_ifc)
  );

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign len_sat = (req.prefix_length > MAX_LEN) ? MAX_LEN : req.prefix_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      cnt      <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      cnt      <= cnt_next;
      rd_valid <= rd_en;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt;
    rsp    <= rsp_next;
    if (accept) begin
      op_mode <= req.mode;
      op_key  <= (req.mode == MODE_LOOKUP) ? req.address : (req.address & len_mask(len_sat));
      op_len  <= len_sat;
      op_ifc  <= req.interface_index;
      op_nh   <= req.next_hop;
    end
  end

  always_comb begin
    state_next   = state;
    cnt_next     = cnt;
    wr_en        = 1'b0;
    wr_addr      = cnt;
    wr_data      = '0;
    rd_en        = 1'b0;
    sctrl.clear  = 1'b0;
    sctrl.sample = rd_valid;
    done_next    = 1'b0;
    rsp_next     = '0;
    rsp_next.status = ST_MISS;

    case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (cnt == LAST_IDX) begin
          cnt_next   = '0;
          state_next = S_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          sctrl.clear = 1'b1;
          cnt_next    = '0;
          state_next  = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_en = 1'b1;
        if (cnt == LAST_IDX) begin
          cnt_next   = '0;
          state_next = S_DRAIN;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        done_next  = 1'b1;
        state_next = S_IDLE;
        wr_data.valid  = 1'b1;
        wr_data.prefix = op_key;
        wr_data.length = op_len;
        wr_data.ifc    = op_ifc;
        wr_data.nh     = op_nh;
        case (op_mode)
          MODE_INSERT: begin
            if (flags.exact_hit) begin
              wr_en   = 1'b1;
              wr_addr = exact_slot;
              rsp_next.status = ST_OK;
            end else if (flags.free_hit) begin
              wr_en   = 1'b1;
              wr_addr = free_slot;
              rsp_next.status = ST_OK;
            end else begin
              rsp_next.status = ST_FULL;
            end
          end
          MODE_DELETE: begin
            wr_data.valid = 1'b0;
            if (flags.exact_hit) begin
              wr_en   = 1'b1;
              wr_addr = exact_slot;
              rsp_next.status = ST_OK;
            end
          end
          MODE_LOOKUP: begin
            if (flags.best_hit) begin
              rsp_next.status        = ST_OK;
              rsp_next.out_next_hop  = best_nh;
              rsp_next.out_interface = best_ifc;
            end
          end
          default: begin
            rsp_next.status = ST_MISS;
          end
        endcase
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  a_single_beat: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two result beats in a row");

  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_OK) |-> (rsp.out_next_hop == 32'h0 && rsp.out_interface == 8'h0))
    else $error("non-zero payload on failed result");

endmodule
